// File: src/g711_pkg.sv
// Shared types, constants and companding functions for the G.711 codec.
// Used by the channel interfaces and the codec top level; no dependencies.

package g711_pkg;

    typedef logic [7:0]        code_t;
    typedef logic signed [15:0] sample_t;

    localparam logic [16:0] MU_CLIP    = 17'd32635;
    localparam logic [16:0] MU_BIAS    = 17'd132;
    localparam logic [7:0]  A_TOGGLE   = 8'h55;
    localparam logic [15:0] A_SEG_BASE = 16'h0108;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic LAW_MU = 1'b0;
    localparam logic LAW_A  = 1'b1;

    function automatic code_t mu_encode(input logic [15:0] s);
        logic        neg;
        logic [16:0] mag;
        logic [14:0] biased;
        logic [2:0]  seg;
        logic [3:0]  man;
        neg = s[15];
        mag = neg ? 17'(17'h10000 - {1'b0, s}) : {1'b0, s};
        if (mag > MU_CLIP)
        begin
            mag = MU_CLIP;
        end
        biased = 15'(mag + MU_BIAS);
        seg = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (biased[7 + i])
            begin
                seg = 3'(i);
            end
        end
        man = 4'(biased >> (4'(seg) + 4'd3));
        return ~{neg, seg, man};
    endfunction

    function automatic logic [15:0] mu_decode(input code_t code);
        code_t       u;
        logic [2:0]  seg;
        logic [3:0]  man;
        logic [15:0] base;
        logic [15:0] t;
        u = ~code;
        seg = u[6:4];
        man = u[3:0];
        base = 16'({man, 3'b000}) + 16'(MU_BIAS);
        t = 16'((base << seg) - 16'(MU_BIAS));
        return u[7] ? 16'(16'd0 - t) : t;
    endfunction

    function automatic code_t a_encode(input logic [15:0] s);
        logic        neg;
        logic [14:0] mag;
        logic [2:0]  seg;
        logic [3:0]  man;
        neg = s[15];
        mag = neg ? ~s[14:0] : s[14:0];
        seg = 3'd0;
        if (mag < 15'd256)
        begin
            man = mag[7:4];
        end
        else
        begin
            for (int i = 0; i < 7; i++)
            begin
                if (mag[8 + i])
                begin
                    seg = 3'(i + 1);
                end
            end
            man = 4'(mag >> (4'(seg) + 4'd3));
        end
        return {~neg, seg, man} ^ A_TOGGLE;
    endfunction

    function automatic logic [15:0] a_decode(input code_t code);
        code_t       a;
        logic [2:0]  seg;
        logic [3:0]  man;
        logic [15:0] t;
        a = code ^ A_TOGGLE;
        seg = a[6:4];
        man = a[3:0];
        if (seg == 3'd0)
        begin
            t = 16'({man, 4'b0000}) + 16'd8;
        end
        else
        begin
            t = 16'((16'({man, 4'b0000}) + A_SEG_BASE) << (seg - 3'd1));
        end
        return a[7] ? t : 16'(16'd0 - t);
    endfunction

endpackage

// File: src/g711_if.sv
// Valid/ready channel interfaces for the G.711 codec: input items, results
// and the configuration write channel. Depends on g711_pkg.

interface g711_in_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    g711_pkg::sample_t        linear_sample;
    g711_pkg::code_t          code_in;

    modport source (output valid, operation, linear_sample, code_in, input ready);
    modport sink   (input valid, operation, linear_sample, code_in, output ready);
    modport mon    (input valid, ready, operation, linear_sample, code_in);
endinterface

interface g711_out_if;
    logic                     valid;
    logic                     ready;
    g711_pkg::code_t          code_result;
    g711_pkg::sample_t        linear_result;

    modport source (output valid, code_result, linear_result, input ready);
    modport sink   (input valid, code_result, linear_result, output ready);
    modport mon    (input valid, ready, code_result, linear_result);
endinterface

interface g711_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
    modport mon    (input valid, ready, data);
endinterface

// File: src/g711_law_codec.sv
// G.711 mu-law / A-law codec top level with a two-register pipeline.
// Depends on g711_pkg and the channel interfaces in g711_if.sv.
//
// Usage:
// The sample_in channel carries one item per transfer: an operation bit
// (encode or decode), a 16-bit PCM sample and an 8-bit code byte. Each
// item yields exactly one transfer on result_out, holding the code byte
// when encoding or the PCM sample when decoding, the other field zero.
// The cfg channel writes the law select bit (0 mu-law, 1 A-law); it is
// always ready and should be written only while no item is in flight.
// An input transfer loads the input register; the conversion logic then
// loads the result register, which offers the result on result_out.
// Throughput is one item per cycle while the receiver takes results; the
// rate is set by the single conversion stage, taking a new item every cycle.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item before sample_in.ready drops.
// Reset clears both pipeline valid bits and selects mu-law.

module g711_law_codec
(
    input  logic           clk,
    input  logic           rst_n,
    g711_in_if.sink        sample_in,
    g711_out_if.source     result_out,
    g711_cfg_if.sink       cfg
);

    logic              law_reg;
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [15:0]       s1_sample_reg;
    g711_pkg::code_t   s1_code_reg;
    logic              s2_valid_reg;
    g711_pkg::code_t   res_code_reg;
    logic [15:0]       res_lin_reg;
    g711_pkg::code_t   res_code_next;
    logic [15:0]       res_lin_next;
    logic              s1_free;
    logic              s2_free;

    assign cfg.ready = 1'b1;

    assign s2_free = !s2_valid_reg || result_out.ready;
    assign s1_free = !s1_valid_reg || s2_free;
    assign sample_in.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg      <= g711_pkg::LAW_MU;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                law_reg <= cfg.data;
            end
            if (s1_free)
            begin
                s1_valid_reg <= sample_in.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && sample_in.valid)
        begin
            s1_op_reg     <= sample_in.operation;
            s1_sample_reg <= sample_in.linear_sample;
            s1_code_reg   <= sample_in.code_in;
        end
        if (s2_free && s1_valid_reg)
        begin
            res_code_reg <= res_code_next;
            res_lin_reg  <= res_lin_next;
        end
    end

    always_comb
    begin
        res_code_next = '0;
        res_lin_next  = '0;
        case (s1_op_reg)
            g711_pkg::OP_ENCODE:
            begin
                res_code_next = (law_reg == g711_pkg::LAW_A)
                              ? g711_pkg::a_encode(s1_sample_reg)
                              : g711_pkg::mu_encode(s1_sample_reg);
            end
            g711_pkg::OP_DECODE:
            begin
                res_lin_next = (law_reg == g711_pkg::LAW_A)
                             ? g711_pkg::a_decode(s1_code_reg)
                             : g711_pkg::mu_decode(s1_code_reg);
            end
            default:
            begin
                res_code_next = '0;
                res_lin_next  = '0;
            end
        endcase
    end

    assign result_out.valid         = s2_valid_reg;
    assign result_out.code_result   = res_code_reg;
    assign result_out.linear_result = res_lin_reg;

endmodule

// File: src/g711_checker.sv
// Port-level assertions for the G.711 codec and the bind that attaches them.
// Depends on g711_pkg and on the ports of g711_law_codec.

module g711_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  g711_pkg::code_t   out_code,
    input  g711_pkg::sample_t out_linear
);

    // A pending result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_code) && $stable(out_linear))
        else $error("result payload changed while stalled");

    // Each result carries either a code byte or a sample, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_code == 8'd0 || out_linear == 16'sd0)
        else $error("both result fields are nonzero");

    // A receiver that takes results never blocks the input.
    assert property (@(posedge clk)
        out_ready |-> in_ready)
        else $error("input blocked while the receiver is ready");

    // No result is offered while reset is held.
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind g711_law_codec g711_checker u_g711_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (sample_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_code   (result_out.code_result),
    .out_linear (result_out.linear_result)
);
